@@ hdl/sorted_key_extent_table_core_assert.svh @@
// assertion macros for the sorted key extent table checker
// expects clk and rst in the scope of each use
`ifndef SORTED_KEY_EXTENT_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_EXTENT_TABLE_CORE_ASSERT_SVH

// same-cycle implication, ignored during reset
`define SKET_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sket assertion failed");

// next-cycle implication, ignored during reset
`define SKET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sket assertion failed");

// next-cycle implication that also holds across reset
`define SKET_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sket assertion failed");

`endif

@@ hdl/sket_pkg.sv @@
// shared codes and control types for the sorted key extent table
// no dependencies
package sket_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_HIT       = 3'd2;
  localparam logic [2:0] ST_MISS      = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam int IN_W  = 96;
  localparam int OUT_W = 144;

  typedef struct packed {
    logic       load;
    logic       rd_scan;
    logic       idx_inc;
    logic       capture;
    logic       rd_last;
    logic       wr_insert;
    logic       wr_move;
    logic       set_status;
    logic [2:0] status;
    logic       out_load;
  } sket_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       scan_done;
    logic       match;
    logic       full;
  } sket_stat_t;

endpackage

@@ hdl/sket_dp.sv @@
// datapath: operand registers, compacted entry memory, count, total and result register
// depends on sket_pkg
module sket_dp import sket_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IN_W-1:0]   in_data,
  input  sket_cmd_t         cmd,
  output sket_stat_t        stat,
  output logic [OUT_W-1:0]  out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = 94;

  logic [1:0]    func;
  logic [31:0]   key;
  logic [30:0]   lba;
  logic [30:0]   len;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic [62:0]   total;
  logic [AW-1:0] slot;
  logic [EW-1:0] rdata;
  logic [2:0]    st;
  logic [30:0]   flba;
  logic [30:0]   flen;
  logic [EW-1:0] mem [CAPACITY];

  logic [CW-1:0] last;
  logic [AW-1:0] raddr;
  logic [63:0]   sum;

  assign last  = count - CW'(1);
  assign raddr = cmd.rd_last ? last[AW-1:0] : idx[AW-1:0];
  assign sum   = {1'b0, total} + {33'd0, len};

  assign stat.func      = func;
  assign stat.scan_done = (idx == count);
  assign stat.match     = (rdata[93:62] == key);
  assign stat.full      = (count == CW'(CAPACITY));

  always_ff @(posedge clk) begin
    if (cmd.wr_insert) begin
      mem[count[AW-1:0]] <= {key, lba, len};
    end else if (cmd.wr_move) begin
      mem[slot] <= rdata;
    end
    if (cmd.rd_scan || cmd.rd_last) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= in_data[1:0];
      key  <= in_data[33:2];
      lba  <= in_data[64:34];
      len  <= in_data[95:65];
      idx  <= '0;
      flba <= '0;
      flen <= '0;
      st   <= ST_MISS;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (cmd.capture) begin
        slot <= idx[AW-1:0];
        flba <= rdata[61:31];
        flen <= rdata[30:0];
      end
      if (cmd.set_status) begin
        st <= cmd.status;
      end
    end
    if (cmd.out_load) begin
      out_data <= {5'd0, total, 11'(count), flen, flba, st};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.wr_insert) begin
      count <= count + CW'(1);
      total <= sum[63] ? {63{1'b1}} : sum[62:0];
    end else if (cmd.wr_move) begin
      count <= last;
    end
  end

endmodule

@@ hdl/sket_ctrl.sv @@
// controller: sequences the key scan, insert, remove and result hand-off
// depends on sket_pkg
module sket_ctrl import sket_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  sket_stat_t stat,
  output sket_cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_CMP, S_MOVE, S_DONE} state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.func == FUNC_UNUSED) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_MISS;
          state_next     = S_DONE;
        end else if (stat.scan_done) begin
          cmd.set_status = 1'b1;
          state_next     = S_DONE;
          if (stat.func == FUNC_INSERT) begin
            if (stat.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.wr_insert = 1'b1;
              cmd.status    = ST_INSERTED;
            end
          end else begin
            cmd.status = ST_MISS;
          end
        end else begin
          cmd.rd_scan = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.match) begin
          cmd.capture    = 1'b1;
          cmd.set_status = 1'b1;
          case (stat.func)
            FUNC_INSERT: begin
              cmd.status = ST_DUPLICATE;
              state_next = S_DONE;
            end
            FUNC_SEARCH: begin
              cmd.status = ST_HIT;
              state_next = S_DONE;
            end
            default: begin
              cmd.status  = ST_REMOVED;
              cmd.rd_last = 1'b1;
              state_next  = S_MOVE;
            end
          endcase
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_MOVE: begin
        cmd.wr_move = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/sorted_key_extent_table_core.sv @@
// top level of the sorted key extent table
// depends on sket_pkg, sket_ctrl and sket_dp
//
// one input item carries an operation (insert, search, remove) with a key and
// an extent; exactly one result item comes back with a status, the found
// extent, the entry count and the saturating total of inserted lengths.
// entries are kept packed in slots 0..count-1 of a single-port-write memory;
// remove moves the last entry into the freed slot.
// each item walks the stored keys one entry at a time, in S_CHECK and S_CMP,
// with the registered memory read feeding the key compare; a remove adds
// an S_MOVE step that writes the last entry into the freed slot.
// one item is worked on at a time; s_tready is high while idle.
// the result waits in an output register, so a new item is accepted while
// the receiver stalls; the finished next result then waits for that register.
// reset (synchronous, active high) empties the table and clears the total at
// once; no clearing pass is needed.
module sorted_key_extent_table_core import sket_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // func[1:0], key[33:2], lba[64:34], length[95:65]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // status[2:0], found_lba[33:3], found_length[64:34], entry_count[75:65],
  // total_size[138:76], zero fill
  output logic [OUT_W-1:0] m_tdata
);

  sket_cmd_t  cmd;
  sket_stat_t stat;

  sket_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sket_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (m_tdata)
  );

endmodule

@@ hdl/sket_chk.sv @@
// port-level checker for the sorted key extent table, bound to the top level
// depends on sket_pkg and sorted_key_extent_table_core_assert.svh
`include "sorted_key_extent_table_core_assert.svh"

module sket_chk import sket_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic no_extent;

  // statuses that carry no found extent
  assign no_extent = (m_tdata[2:0] == ST_INSERTED) || (m_tdata[2:0] == ST_MISS) ||
                     (m_tdata[2:0] == ST_FULL);

  `SKET_ASSERT_ALWAYS(a_reset_empty, rst, !m_tvalid)
  `SKET_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SKET_ASSERT_NOW(a_count_bound, m_tvalid && (CAPACITY <= 2047), m_tdata[75:65] <= 11'(CAPACITY))
  `SKET_ASSERT_NOW(a_no_extent, m_tvalid && no_extent, m_tdata[64:3] == '0)
  `SKET_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

bind sorted_key_extent_table_core sket_chk #(.CAPACITY(CAPACITY)) u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
